>>> hdl/fbk_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fbk_pkg: shared types and helpers for the float bucketizer.
// Holds the operation codes, the token word that runs along the cell chain,
// and the IEEE-754 single less-than compare.
// ----------------------------------------------------------------------------
package fbk_pkg;

  localparam int unsigned MAX_BOUNDARIES_DEF = 256;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  // Query word handed from cell to cell; the running count travels beside it.
  typedef struct packed {
    logic        vld;
    logic [31:0] value;
    logic        last;
  } tok_t;

  // IEEE-754 single a < b. NaN on either side compares false; -0 equals +0.
  function automatic logic fp_lt(input logic [31:0] a, input logic [31:0] b);
    logic a_nan;
    logic b_nan;
    logic res;
    a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    if (a_nan || b_nan) begin
      res = 1'b0;
    end else if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) begin
      res = 1'b0;
    end else if (a[31] != b[31]) begin
      res = a[31];
    end else if (!a[31]) begin
      res = a[30:0] < b[30:0];
    end else begin
      res = a[30:0] > b[30:0];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

>>> hdl/fbk_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fbk_cell: one boundary cell of the bucketizer chain.
// Holds one boundary, compares it against the passing query word and hands
// the word with its updated count to the next cell.
// ----------------------------------------------------------------------------
module fbk_cell #(
  parameter int unsigned CW = 9
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          used,
  input  wire logic          side,
  input  wire logic          wr_en,
  input  wire logic [31:0]   wr_data,
  input  wire fbk_pkg::tok_t tok_in,
  input  wire logic [CW-1:0] cnt_in,
  output fbk_pkg::tok_t      tok_out,
  output logic [CW-1:0]      cnt_out
);
  import fbk_pkg::*;

  logic [31:0] boundary;
  logic        hit;

  // Stored boundary; contents are only meaningful once written.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      boundary <= wr_data;
    end
  end

  // Left mode counts boundary < value, right mode counts !(value < boundary).
  always_comb begin
    if (side) begin
      hit = !fp_lt(tok_in.value, boundary);
    end else begin
      hit = fp_lt(boundary, tok_in.value);
    end
  end

  // Hand the word and its running count to the next cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.vld <= 1'b0;
    end else begin
      tok_out.vld <= tok_in.vld;
    end
    tok_out.value <= tok_in.value;
    tok_out.last  <= tok_in.last;
    cnt_out       <= cnt_in + CW'(used && hit);
  end

endmodule
`default_nettype wire

>>> hdl/float_bucketize_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// float_bucketize_core: bucket index of float32 values against a boundary table.
// A query word walks a chain of one cell per boundary slot.
// ----------------------------------------------------------------------------
// Clear and append words never raise busy. A query raises busy; its word
// passes the boundary cells in turn, then the output register, which returns
// its bucket. The result is shown for one cycle with done high; the receiver
// cannot stall, so it must take every result in that cycle. Appends beyond
// MAX_BOUNDARIES are dropped and set the sticky overflow flag. No clearing
// pass after reset.
module float_bucketize_core #(
  parameter int unsigned MAX_BOUNDARIES = fbk_pkg::MAX_BOUNDARIES_DEF,
  localparam int unsigned CW = $clog2(MAX_BOUNDARIES + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire logic [1:0]    mode,
  input  wire logic [31:0]   value,
  input  wire logic          last,
  output logic               done,
  output logic [CW-1:0]      bucket,
  output logic               table_overflow,
  output logic               last_out,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic          cfg_data
);
  import fbk_pkg::*;

  logic          right_side;
  logic [CW-1:0] count;
  logic          overflow_flag;
  logic          accept;
  tok_t          tok [MAX_BOUNDARIES+1];
  logic [CW-1:0] cnt [MAX_BOUNDARIES+1];

  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      right_side <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      right_side <= cfg_data;
    end
  end

  // Fill count and sticky overflow.
  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      overflow_flag <= 1'b0;
    end else if (accept && mode == OP_CLEAR) begin
      count         <= '0;
      overflow_flag <= 1'b0;
    end else if (accept && mode == OP_APPEND) begin
      if (count < CW'(MAX_BOUNDARIES)) begin
        count <= count + CW'(1);
      end else begin
        overflow_flag <= 1'b1;
      end
    end
  end

  // Query word entering the head of the chain.
  assign tok[0] = '{vld: accept && (mode == OP_QUERY), value: value, last: last};
  assign cnt[0] = '0;

  for (genvar i = 0; i < MAX_BOUNDARIES; i++) begin : g_cell
    fbk_cell #(.CW(CW)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .used    (CW'(i) < count),
      .side    (right_side),
      .wr_en   (accept && mode == OP_APPEND && count == CW'(i)),
      .wr_data (value),
      .tok_in  (tok[i]),
      .cnt_in  (cnt[i]),
      .tok_out (tok[i+1]),
      .cnt_out (cnt[i+1])
    );
  end

  // Busy from query entry until the word leaves the chain.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= tok[MAX_BOUNDARIES].vld;
      if (tok[0].vld) begin
        busy <= 1'b1;
      end else if (tok[MAX_BOUNDARIES].vld) begin
        busy <= 1'b0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (tok[MAX_BOUNDARIES].vld) begin
      bucket         <= cnt[MAX_BOUNDARIES];
      table_overflow <= overflow_flag;
      last_out       <= tok[MAX_BOUNDARIES].last;
    end
  end

endmodule
`default_nettype wire

>>> hdl/fbk_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fbk_checker: port-level checks for the float bucketizer.
// Watches the command handshake and the result strobe over time.
// ----------------------------------------------------------------------------
module fbk_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic [1:0] mode,
  input wire logic       done
);
  import fbk_pkg::*;

  // A taken query holds the block busy.
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && mode == OP_QUERY) |=> busy)
    else $error("query did not raise busy");

  // Each result shows for a single cycle.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  // A result appears only as busy falls.
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> (!busy && $past(busy)))
    else $error("result without a finishing query");

endmodule

bind float_bucketize_core fbk_checker u_fbk_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .mode  (mode),
  .done  (done)
);
`default_nettype wire

>>> tb/tb_float_bucketize_core.sv
// ----------------------------------------------------------------------------
// Float bucketizer testbench
// Loads boundary tables through clear and append words, sends query words in
// both left and right mode, and checks every bucket, overflow flag and last
// marker against a behavioral model of the table kept inside the bench.
// ----------------------------------------------------------------------------
module tb_float_bucketize_core;
  import fbk_pkg::*;

  localparam int unsigned DEPTH = MAX_BOUNDARIES_DEF;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned DRAIN_CYCLES = DEPTH + 20;
  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [CW-1:0] bucket;
    logic          overflow;
    logic          last;
  } bucket_word_t;

  logic          clk;
  logic          rst;
  logic          start;
  logic          busy;
  logic [1:0]    mode_in;
  logic [31:0]   value_in;
  logic          last_in;
  logic          done;
  logic [CW-1:0] bucket;
  logic          table_overflow;
  logic          last_out;
  logic          cfg_valid;
  logic          cfg_ready;
  logic          cfg_data;

  // Model of the boundary table and the mode register.
  logic [31:0]   bound_mem [DEPTH];
  int unsigned   bound_count;
  logic          ovf_sticky;
  logic          right_mode;

  bucket_word_t  pending_buckets [$];
  int unsigned   errors;
  int unsigned   cycles;
  int unsigned   words_sent;
  bit            idle_enabled;

  float_bucketize_core DUT (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .mode           (mode_in),
    .value          (value_in),
    .last           (last_in),
    .done           (done),
    .bucket         (bucket),
    .table_overflow (table_overflow),
    .last_out       (last_out),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Map a float to an unsigned key that sorts like the number; -0 folds to +0.
  function automatic logic [31:0] order_key(input logic [31:0] f);
    logic [31:0] k;
    if (f[30:0] == 31'd0) begin
      k = 32'h8000_0000;
    end else if (f[31]) begin
      k = ~f;
    end else begin
      k = f | 32'h8000_0000;
    end
    return k;
  endfunction

  function automatic logic is_nan(input logic [31:0] f);
    return (f[30:23] == 8'hFF) && (f[22:0] != 23'd0);
  endfunction

  function automatic logic float_below(input logic [31:0] a, input logic [31:0] b);
    if (is_nan(a) || is_nan(b)) begin
      return 1'b0;
    end
    return order_key(a) < order_key(b);
  endfunction

  // Apply one accepted word to the table model; queries yield a bucket.
  task automatic bucketize_word(input logic [1:0] op, input logic [31:0] v,
                                input logic lst);
    bucket_word_t r;
    int unsigned n;
    n = 0;
    case (op)
      OP_CLEAR: begin
        bound_count = 0;
        ovf_sticky = 1'b0;
      end
      OP_APPEND: begin
        if (bound_count < DEPTH) begin
          bound_mem[bound_count] = v;
          bound_count++;
        end else begin
          ovf_sticky = 1'b1;
        end
      end
      OP_QUERY: begin
        for (int i = 0; i < bound_count; i++) begin
          if (right_mode ? !float_below(v, bound_mem[i]) : float_below(bound_mem[i], v))
            n++;
        end
        r.bucket = n[CW-1:0];
        r.overflow = ovf_sticky;
        r.last = lst;
        pending_buckets.push_back(r);
      end
      default: begin
      end
    endcase
  endtask

  // Check each result word against the oldest pending bucket.
  always @(posedge clk) begin
    bucket_word_t e;
    if (!rst && done) begin
      if (pending_buckets.size() == 0) begin
        $display("%0t: unexpected result bucket=%0d ovf=%0b last=%0b",
                 $time, bucket, table_overflow, last_out);
        errors++;
      end else begin
        e = pending_buckets.pop_front();
        if (bucket !== e.bucket) begin
          $display("%0t: bucket expected %0d actual %0d", $time, e.bucket, bucket);
          errors++;
        end
        if (table_overflow !== e.overflow) begin
          $display("%0t: table_overflow expected %0b actual %0b", $time,
                   e.overflow, table_overflow);
          errors++;
        end
        if (last_out !== e.last) begin
          $display("%0t: last_out expected %0b actual %0b", $time, e.last, last_out);
          errors++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("float_bucketize_core verification failed");
      $finish;
    end
  end

  // Send one word; start stays high afterward until a later idle gap or wait_idle lowers it.
  task automatic send_word(input logic [1:0] op, input logic [31:0] v, input logic lst);
    int unsigned gap;
    if (idle_enabled && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        start = 1'b0;
      end
    end
    @(negedge clk);
    start = 1'b1;
    mode_in = op;
    value_in = v;
    last_in = lst;
    while (busy) @(negedge clk);
    @(posedge clk);
    bucketize_word(op, v, lst);
    words_sent++;
  endtask

  // Hold off until every pending bucket is back and the chain is empty.
  task automatic wait_idle();
    @(negedge clk);
    start = 1'b0;
    while (pending_buckets.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_side(input logic side);
    wait_idle();
    cfg_valid = 1'b1;
    cfg_data = side;
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    right_mode = side;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [31:0] pick_float();
    logic [31:0] pool [14] = '{32'h0000_0000, 32'h8000_0000, 32'h3F80_0000,
                               32'hBF80_0000, 32'h7F80_0000, 32'hFF80_0000,
                               32'h7FC0_0000, 32'h0000_0001, 32'h8000_0001,
                               32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h3F00_0000,
                               32'h4000_0000, 32'hC000_0000};
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return {$urandom_range(0, 1) == 1, 8'd126 + 8'($urandom_range(0, 4)),
                 23'($urandom_range(0, 3)) << 21};
      default: return pool[$urandom_range(0, 13)];
    endcase
  endfunction

  // Edge values in left mode, including signed zeros, infinities and NaN queries.
  task automatic test_extremes();
    send_word(OP_CLEAR, 32'h0, 1'b0);
    send_word(OP_APPEND, 32'h0000_0000, 1'b0);
    send_word(OP_APPEND, 32'h8000_0000, 1'b0);
    send_word(OP_APPEND, 32'hFF80_0000, 1'b0);
    send_word(OP_APPEND, 32'h7F80_0000, 1'b0);
    send_word(OP_APPEND, 32'h3F80_0000, 1'b0);
    send_word(OP_QUERY, 32'h8000_0000, 1'b1);
    send_word(OP_QUERY, 32'h7FFF_FFFF, 1'b0);
    send_word(OP_QUERY, 32'hFFFF_FFFF, 1'b1);
    send_word(OP_UNUSED, 32'h3F80_0000, 1'b1);
    send_word(OP_QUERY, 32'h3F80_0000, 1'b0);
    send_word(OP_QUERY, 32'h7F80_0000, 1'b1);
  endtask

  // Right mode with a NaN boundary, then back to left mode.
  task automatic test_right_side();
    write_side(1'b1);
    send_word(OP_APPEND, 32'h7FC0_0001, 1'b0);
    send_word(OP_QUERY, 32'h0000_0000, 1'b1);
    send_word(OP_QUERY, 32'h7FC0_0000, 1'b0);
    send_word(OP_QUERY, 32'hFF80_0000, 1'b0);
    write_side(1'b0);
    send_word(OP_QUERY, 32'h7FC0_0000, 1'b1);
  endtask

  // Fill the table, overrun it, and check that clear drops the sticky flag.
  task automatic test_overflow();
    send_word(OP_CLEAR, 32'h0, 1'b0);
    for (int i = 0; i < DEPTH; i++) send_word(OP_APPEND, pick_float(), 1'b0);
    send_word(OP_QUERY, 32'h7F80_0000, 1'b1);
    send_word(OP_APPEND, 32'h3F80_0000, 1'b0);
    write_side(1'b1);
    send_word(OP_QUERY, 32'h7F80_0000, 1'b0);
    send_word(OP_CLEAR, 32'h0, 1'b0);
    send_word(OP_QUERY, 32'h7F80_0000, 1'b1);
  endtask

  // Random tables and queries, with some noise words and mode flips.
  task automatic test_random(input int unsigned budget);
    int unsigned goal;
    int unsigned n;
    goal = words_sent + budget;
    while (words_sent < goal) begin
      if (words_sent + 150 > goal) idle_enabled = 1'b0;
      if ($urandom_range(0, 9) == 0) write_side($urandom_range(0, 1) == 1);
      if ($urandom_range(0, 11) == 0) wait_idle();
      send_word($urandom_range(0, 7) == 0 ? OP_UNUSED : OP_CLEAR, pick_float(),
                $urandom_range(0, 1) == 1);
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(200, 262) : $urandom_range(0, 10);
      for (int i = 0; i < n; i++) begin
        send_word($urandom_range(0, 29) == 0 ? OP_UNUSED : OP_APPEND, pick_float(),
                  $urandom_range(0, 1) == 1);
      end
      n = $urandom_range(1, 5);
      for (int i = 0; i < n; i++) send_word(OP_QUERY, pick_float(), $urandom_range(0, 1) == 1);
    end
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    words_sent = 0;
    idle_enabled = 1'b1;
    bound_count = 0;
    ovf_sticky = 1'b0;
    right_mode = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    mode_in = OP_CLEAR;
    value_in = 32'h0;
    last_in = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = 1'b0;
    repeat (3) @(negedge clk);
    rst = 1'b0;

    write_side(1'b0);
    test_extremes();
    test_right_side();
    test_overflow();
    test_random(1100);

    wait_idle();
    if (errors == 0) begin
      $display("float_bucketize_core verification clean");
    end else begin
      $display("float_bucketize_core verification failed");
    end
    $finish;
  end

endmodule
